[rtl/core/ppc_pkg.sv]
// shared types and constants of the pid pwm controller
package ppc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 10;
    localparam int ERR_W    = 9;
    localparam int ISUM_W   = 32;
    localparam int CFG_AW   = 8;
    localparam int CFG_DW   = 16;
    localparam int MUL_W    = 18;
    localparam int PROD_W   = 2 * MUL_W;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_REFERENCE      = 8'd0;
    localparam logic [CFG_AW-1:0] REG_PROP_GAIN      = 8'd1;
    localparam logic [CFG_AW-1:0] REG_INTEG_GAIN     = 8'd2;
    localparam logic [CFG_AW-1:0] REG_DERIV_GAIN     = 8'd3;
    localparam logic [CFG_AW-1:0] REG_TIME_STEP      = 8'd4;
    localparam logic [CFG_AW-1:0] REG_INV_TIME_STEP  = 8'd5;
    localparam logic [CFG_AW-1:0] REG_INTEGRAL_LIMIT = 8'd6;
    localparam logic [CFG_AW-1:0] REG_OUTPUT_MAX     = 8'd7;

    // derivative band limits and the high-sample threshold
    localparam int BAND_ERR_OUTER  = 22;
    localparam int BAND_ERR_INNER  = 10;
    localparam int BAND_PREV_ERR   = 25;
    localparam int BAND_DUTY_LOW   = 15;
    localparam int HIGH_SAMPLE     = 230;

    typedef logic signed [MUL_W-1:0]  mul_opnd_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;

    typedef struct packed {
        mul_opnd_t a;
        mul_opnd_t b;
    } mul_req_t;

endpackage

[rtl/core/ppc_mul.sv]
// shared signed multiplier with registered product
module ppc_mul
    import ppc_pkg::*;
(
    input  logic      aclk,
    input  mul_req_t  req,
    output mul_prod_t prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= req.a * req.b;
    end

endmodule

[rtl/core/pid_pwm_controller.sv]
// pid pwm duty controller with anti-windup, top level
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one 8-bit measured sample per request.
//   m_tvalid/m_tready/m_tdata carry the new pwm duty (10 bits), m_tuser
//   flags that the derivative band held for this step.
//   cfg_valid/cfg_ready/cfg_addr/cfg_data write the eight gain and limit
//   registers; write them only while no sample is in flight.
// sequencing:
//   the sequencer drives one shared 18x18 multiplier through the p,
//   integral, derivative and gain products one per step, and a new
//   sample is taken only once the last one has left the sequencer;
//   s_tready is high only while the sequencer idles.
// reset:
//   aresetn (synchronous, active low) loads the register defaults and clears
//   the integral, the previous error and the previous duty.
// stall:
//   a finished result waits in the output register; a later result holds in
//   the last sequencer step until the receiver takes the earlier one.
module pid_pwm_controller
    import ppc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] measured_sample

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [9:0] pwm_duty, [15:10] zero
    output logic [0:0]        m_tuser,   // [0] derivative_used

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_E,
        ST_ACC,
        ST_DIV,
        ST_CLAMP,
        ST_MUL_I,
        ST_SUM_I,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [SAMPLE_W-1:0] reference_reg;
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   integ_gain_reg;
    logic [GAIN_W-1:0]   deriv_gain_reg;
    logic [GAIN_W-1:0]   time_step_reg;
    logic [GAIN_W-1:0]   inv_step_reg;
    logic [GAIN_W-1:0]   integral_limit_reg;
    logic [DUTY_W-1:0]   output_max_reg;

    // controller state
    logic signed [ISUM_W-1:0] isum_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic [DUTY_W-1:0]        prev_duty_reg;

    // per-sample datapath
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W:0]   diff_reg;     // err minus previous error
    logic                    band_reg;
    logic signed [40:0]      acc_reg;      // integral sum in q.16
    logic signed [24:0]      ival_reg;     // whole integral value
    logic signed [10:0]      d_reg;        // clamped derivative
    logic signed [27:0]      dterm_reg;    // derivative term in q.8
    logic signed [35:0]      total_reg;    // output sum in q.8

    logic [DUTY_W-1:0] duty_reg;
    logic              used_reg;
    logic              m_valid_reg;

    // shared multiplier
    mul_req_t  mreq;
    mul_prod_t prod_reg;

    ppc_mul u_mul (
        .aclk     (aclk),
        .req      (mreq),
        .prod_reg (prod_reg)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, duty_reg};
    assign m_tuser   = used_reg;

    // operand select for the shared multiplier, one product per step
    always_comb begin
        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            ST_MUL_P: begin
                mreq.a = $signed({2'b00, prop_gain_reg});
                mreq.b = MUL_W'(err_reg);
            end
            ST_MUL_E: begin
                mreq.a = $signed({2'b00, time_step_reg});
                mreq.b = MUL_W'(err_reg);
            end
            ST_ACC: begin
                mreq.a = $signed({2'b00, inv_step_reg});
                mreq.b = MUL_W'(diff_reg);
            end
            ST_CLAMP: begin
                mreq.a = $signed({2'b00, deriv_gain_reg});
                mreq.b = MUL_W'(d_reg);
            end
            ST_MUL_I: begin
                // clamped integral fits 18 signed bits
                mreq.a = $signed({2'b00, integ_gain_reg});
                mreq.b = MUL_W'(ival_reg);
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // derivative band test on the fresh error
    logic band_next;
    always_comb begin
        band_next = (err_reg > -ERR_W'(BAND_ERR_OUTER)) &&
                    (err_reg <  ERR_W'(BAND_ERR_OUTER)) &&
                    ((err_reg < -ERR_W'(BAND_ERR_INNER)) ||
                     (err_reg >  ERR_W'(BAND_ERR_INNER))) &&
                    (prev_err_reg > -ERR_W'(BAND_PREV_ERR)) &&
                    (prev_err_reg <  ERR_W'(BAND_PREV_ERR)) &&
                    (prev_duty_reg > DUTY_W'(BAND_DUTY_LOW)) &&
                    (prev_duty_reg < output_max_reg);
    end

    // integral accumulate, truncating divide and clamps
    logic signed [40:0] acc_next;
    logic signed [24:0] quot;
    logic signed [24:0] lim_s;
    logic signed [35:0] omax_s;
    logic signed [28:0] isum_new;
    logic [27:0]        whole;
    logic [DUTY_W-1:0]  duty_next;

    always_comb begin
        acc_next = $signed({isum_reg[ISUM_W-1], isum_reg, 8'd0}) + 41'(prod_reg);
        // toward zero: round negative quotients up when bits are dropped
        quot     = acc_reg[40:16] + 25'(acc_reg[40] && (acc_reg[15:0] != 16'd0));
        lim_s    = $signed({9'd0, integral_limit_reg});
        omax_s   = $signed({26'd0, output_max_reg});
        isum_new = err_reg[ERR_W-1] ?
                   ($signed({ival_reg[16:0], 8'd0}) - 29'(dterm_reg)) :
                   ($signed({ival_reg[16:0], 8'd0}) + 29'(dterm_reg));
        whole    = total_reg[35:8];
        if (total_reg <= 36'sd0) begin
            duty_next = '0;
        end else if (whole > {18'd0, output_max_reg}) begin
            duty_next = output_max_reg;
        end else begin
            duty_next = whole[DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            reference_reg      <= 8'd128;
            prop_gain_reg      <= 16'd256;
            integ_gain_reg     <= 16'd0;
            deriv_gain_reg     <= 16'd0;
            time_step_reg      <= 16'd655;
            inv_step_reg       <= 16'd100;
            integral_limit_reg <= 16'd65535;
            output_max_reg     <= 10'd255;
            isum_reg           <= '0;
            prev_err_reg       <= '0;
            prev_duty_reg      <= '0;
        end else begin
            // the output step refills the register itself
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            // register writes, unknown indexes are dropped
            if (cfg_valid) begin
                case (cfg_addr)
                    REG_REFERENCE:      reference_reg      <= cfg_data[7:0];
                    REG_PROP_GAIN:      prop_gain_reg      <= cfg_data;
                    REG_INTEG_GAIN:     integ_gain_reg     <= cfg_data;
                    REG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data;
                    REG_TIME_STEP:      time_step_reg      <= cfg_data;
                    REG_INV_TIME_STEP:  inv_step_reg       <= cfg_data;
                    REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data;
                    REG_OUTPUT_MAX:     output_max_reg     <= cfg_data[9:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        err_reg <= $signed({1'b0, reference_reg}) -
                                   $signed({1'b0, s_tdata});
                        // a high sample dumps the integral
                        if (s_tdata > SAMPLE_W'(HIGH_SAMPLE)) begin
                            isum_reg <= '0;
                        end
                        state_reg <= ST_MUL_P;
                    end
                end
                ST_MUL_P: begin
                    band_reg  <= band_next;
                    diff_reg  <= (ERR_W+1)'(err_reg) - (ERR_W+1)'(prev_err_reg);
                    state_reg <= ST_MUL_E;
                end
                ST_MUL_E: begin
                    total_reg <= prod_reg;                 // proportional term
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg   <= acc_next;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    ival_reg <= quot;
                    if (prod_reg > omax_s) begin
                        d_reg <= $signed({1'b0, output_max_reg});
                    end else if (prod_reg < -omax_s) begin
                        d_reg <= -$signed({1'b0, output_max_reg});
                    end else begin
                        d_reg <= prod_reg[10:0];
                    end
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    if (ival_reg > lim_s) begin
                        ival_reg <= lim_s;
                    end else if (ival_reg < -lim_s) begin
                        ival_reg <= -lim_s;
                    end
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I: begin
                    // product is the derivative term
                    if (band_reg) begin
                        dterm_reg <= prod_reg[27:0];
                        total_reg <= total_reg + prod_reg;
                    end else begin
                        dterm_reg <= '0;
                    end
                    state_reg <= ST_SUM_I;
                end
                ST_SUM_I: begin
                    total_reg <= total_reg + prod_reg;     // integral term
                    isum_reg  <= ISUM_W'(isum_new);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        duty_reg      <= duty_next;
                        used_reg      <= band_reg;
                        m_valid_reg   <= 1'b1;
                        prev_duty_reg <= duty_next;
                        prev_err_reg  <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/tb_pid_pwm_controller.sv]
`timescale 1ns / 100ps
// self-checking testbench of the pid pwm controller, with a duty predictor and result scoreboard
module tb_pid_pwm_controller;
    import ppc_pkg::*;

    localparam int NUM_REGS        = 8;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 24;    // extra wait after the last result comes back
    localparam int RANDOM_PHASES   = 18;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int REPORT_MAX      = 10;
    localparam int RESET_CYCLES    = 7;

    localparam logic [CFG_AW-1:0] REG_FIRST_UNMAPPED = CFG_AW'(NUM_REGS);

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // shadow of the gain and limit registers
    typedef struct packed {
        logic [SAMPLE_W-1:0] reference;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [GAIN_W-1:0]   time_step;
        logic [GAIN_W-1:0]   inv_time_step;
        logic [GAIN_W-1:0]   integral_limit;
        logic [DUTY_W-1:0]   output_max;
    } ctl_regs_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              deriv_used;
    } duty_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;

    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // [7:0] measured_sample

    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;          // [9:0] pwm_duty, [15:10] zero
    logic [0:0]        m_tuser;          // [0] derivative_used

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    // predictor state
    ctl_regs_t ctl;
    int        integ_sum;    // signed q24.8
    int        last_err;
    int        last_duty;

    logic [SAMPLE_W-1:0] sample_queue[$];     // samples waiting to be sent
    duty_result_t        duty_expected[$];    // predicted results, oldest first

    bit  in_fire = 1'b0;     // sample request taken at the last rising edge
    int  sender_idle_pct    = 0;
    int  receiver_stall_pct = 0;
    int  mismatches         = 0;
    int  cycles             = 0;

    pid_pwm_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void reset_model();
        ctl = '{reference: 8'd128, prop_gain: 16'd256, integ_gain: 16'd0,
                deriv_gain: 16'd0, time_step: 16'd655, inv_time_step: 16'd100,
                integral_limit: 16'd65535, output_max: 10'd255};
        integ_sum = 0;
        last_err  = 0;
        last_duty = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_AW-1:0] idx,
                                      input logic [CFG_DW-1:0] val);
        case (idx)
            REG_REFERENCE:      ctl.reference      = val[SAMPLE_W-1:0];
            REG_PROP_GAIN:      ctl.prop_gain      = val;
            REG_INTEG_GAIN:     ctl.integ_gain     = val;
            REG_DERIV_GAIN:     ctl.deriv_gain     = val;
            REG_TIME_STEP:      ctl.time_step      = val;
            REG_INV_TIME_STEP:  ctl.inv_time_step  = val;
            REG_INTEGRAL_LIMIT: ctl.integral_limit = val;
            REG_OUTPUT_MAX:     ctl.output_max     = val[DUTY_W-1:0];
            default: ;          // unmapped index, write dropped
        endcase
    endfunction

    // one control step: returns the duty and band flag, advances the state
    function automatic duty_result_t predict_duty(input logic [SAMPLE_W-1:0] reading);
        longint smp, err, kp, ki, kd, ts, inv, lim, omax;
        longint p_term, i_term, d_term, acc, ival, dval, total;
        bit band;
        duty_result_t res;
        smp  = reading;
        err  = ctl.reference;
        err  = err - smp;
        kp   = ctl.prop_gain;
        ki   = ctl.integ_gain;
        kd   = ctl.deriv_gain;
        ts   = ctl.time_step;
        inv  = ctl.inv_time_step;
        lim  = ctl.integral_limit;
        omax = ctl.output_max;

        p_term = kp * err;

        // a high reading dumps the integral before the update
        if (smp > HIGH_SAMPLE)
            integ_sum = 0;

        // q.16 accumulate, truncate toward zero, clamp, back to q.8
        acc  = integ_sum;
        acc  = acc * 256 + err * ts;
        ival = acc / 65536;
        if (ival > lim)
            ival = lim;
        else if (ival < -lim)
            ival = -lim;
        i_term = ki * ival;
        ival   = ival * 256;

        band = (err > -BAND_ERR_OUTER && err < BAND_ERR_OUTER) &&
               (err < -BAND_ERR_INNER || err > BAND_ERR_INNER) &&
               (last_err > -BAND_PREV_ERR && last_err < BAND_PREV_ERR) &&
               (last_duty > BAND_DUTY_LOW && last_duty < omax);
        d_term = 0;
        if (band) begin
            dval = (err - last_err) * inv;
            if (dval > omax)
                dval = omax;
            else if (dval < -omax)
                dval = -omax;
            d_term = dval * kd;
            // derivative also nudges the integral, in the direction of the error
            if (err < 0)
                ival = ival - d_term;
            else
                ival = ival + d_term;
        end
        integ_sum = int'(ival);
        last_err  = int'(err);

        total = p_term + i_term + d_term;
        if (total <= 0) begin
            res.duty = '0;
        end else begin
            total = total / 256;
            if (total > omax)
                total = omax;
            res.duty = total[DUTY_W-1:0];
        end
        res.deriv_used = band;
        last_duty = res.duty;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request side: shadow registers and predictions on each request taken
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                duty_expected.push_back(predict_duty(s_tdata));
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_addr, cfg_data);
        end
    end

    // sample driver, fed from sample_queue; a pending request holds until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_tdata  <= sample_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input int expv, input int actv);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t ns: %s expected %0d got %0d", $time, what, expv, actv);
    endtask

    always @(posedge aclk) begin : result_check
        duty_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (duty_expected.size() == 0) begin
                note_mismatch("result with no sample pending, pwm_duty", -1,
                              m_tdata[DUTY_W-1:0]);
            end else begin
                want = duty_expected.pop_front();
                // upper tdata bits are padding and must read zero
                if (m_tdata !== 16'(want.duty))
                    note_mismatch("pwm_duty", want.duty, m_tdata);
                if (m_tuser[0] !== want.deriv_used)
                    note_mismatch("derivative_used", want.deriv_used, m_tuser[0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 81;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 81;
            end
            default: begin
                sender_idle_pct = 35;
                receiver_stall_pct = 35;
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // all eight registers; the unused upper data bits carry noise
    task automatic write_all_regs(input logic [SAMPLE_W-1:0] r_ref,
                                  input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                  input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] ts,
                                  input logic [GAIN_W-1:0] inv, input logic [GAIN_W-1:0] lim,
                                  input logic [DUTY_W-1:0] omax);
        write_reg(REG_REFERENCE,      {8'($urandom), r_ref});
        write_reg(REG_PROP_GAIN,      kp);
        write_reg(REG_INTEG_GAIN,     ki);
        write_reg(REG_DERIV_GAIN,     kd);
        write_reg(REG_TIME_STEP,      ts);
        write_reg(REG_INV_TIME_STEP,  inv);
        write_reg(REG_INTEGRAL_LIMIT, lim);
        write_reg(REG_OUTPUT_MAX,     {6'($urandom), omax});
    endtask

    // wait until every sample is sent and every result has come back
    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_tvalid || duty_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // gain: mostly moderate, sometimes zero or full scale
    function automatic logic [GAIN_W-1:0] pick_gain(input int typical);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return GAIN_W'($urandom_range(typical));
    endfunction

    // most readings land near the target so the derivative band gets exercised
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] target);
        int v, off;
        if ($urandom_range(99) < 65) begin
            off = $urandom_range(50);
            v   = target;
            v   = v + off - 25;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
        end else begin
            v = $urandom_range(255);
        end
        return SAMPLE_W'(v);
    endfunction

    initial begin : stimulus
        int ph, k, r;
        logic [SAMPLE_W-1:0] tgt;
        logic [DUTY_W-1:0]   omax;
        logic [GAIN_W-1:0]   ts, lim, inv;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        set_idle(IDLE_NONE);

        // a few samples against the reset defaults
        sample_queue = {8'd0, 8'd255, 8'd128};
        wait_drained();

        // band walk: gains chosen so the duty sits mid-range near the target
        write_all_regs(8'd128, 16'd512, 16'd64, 16'd8, 16'd4096, 16'd100, 16'd1000,
                       10'd255);
        // unmapped index must leave every register untouched
        write_reg(REG_FIRST_UNMAPPED, 16'h0000);
        write_reg(8'hFF, 16'hFFFF);
        sample_queue = {8'd113,     // err 15, lifts duty mid-range
                        8'd110,     // band, positive error
                        8'd143,     // band, negative error
                        8'd113,
                        8'd117,     // err 11, inner band edge
                        8'd107,     // err 21, outer band edge
                        8'd106,     // err 22, just outside
                        8'd118,     // err 10, just outside
                        8'd0,       // largest positive error
                        8'd255,     // high reading clears the integral, largest negative error
                        8'd231,     // just above the high-reading threshold
                        8'd230};    // at the threshold
        wait_drained();

        // zero inverse step: band holds but the derivative is zero
        write_reg(REG_INV_TIME_STEP, 16'd0);
        sample_queue = {8'd113, 8'd110, 8'd143, 8'd113};
        wait_drained();

        // zero integral limit and the smallest output maximum (band can never hold)
        write_reg(REG_INV_TIME_STEP, 16'd100);
        write_reg(REG_INTEGRAL_LIMIT, 16'd0);
        write_reg(REG_OUTPUT_MAX, 16'd16);
        sample_queue = {8'd113, 8'd110, 8'd0, 8'd255, 8'd120};
        wait_drained();

        // random phases, each with its own settings and idle pattern
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idle(idle_mode_t'(ph % 4));
            if (ph == 0) begin
                tgt = 8'd255;
                write_all_regs(tgt, '1, '1, '1, '1, '1, '1, 10'd1023);
            end else if (ph == 1) begin
                tgt = 8'd0;
                write_all_regs(tgt, '0, '0, '0, 16'd1, 16'd1, '0, 10'd16);
            end else begin
                r = $urandom_range(9);
                tgt = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : SAMPLE_W'($urandom_range(215, 40));
                r = $urandom_range(9);
                ts = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : GAIN_W'($urandom_range(16384, 1));
                r = $urandom_range(9);
                inv = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : GAIN_W'($urandom_range(300, 1));
                r = $urandom_range(9);
                lim = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : GAIN_W'($urandom_range(3000));
                r = $urandom_range(9);
                omax = (r == 0) ? 10'd16 : (r == 1) ? 10'd1023 :
                       DUTY_W'($urandom_range(1023, 16));
                write_all_regs(tgt, pick_gain(1023), pick_gain(255), pick_gain(255), ts, inv,
                               lim, omax);
                if ($urandom_range(3) == 0)
                    write_reg(CFG_AW'($urandom_range(255, NUM_REGS)), 16'($urandom));
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                sample_queue.push_back(pick_sample(tgt));
            wait_drained();
        end

        if (mismatches == 0)
            $display("pid_pwm_controller verification clean");
        else
            $display("pid_pwm_controller verification failed");
        $finish;
    end

    // run limit
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("pid_pwm_controller verification failed");
        $finish;
    end

endmodule
